// File: rtl/pse_pkg.sv
// Shared types and codes for the postfix stack evaluator.
package pse_pkg;

  // Fixed widths of the item fields.
  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 7;

  // Token codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_END  = 3'd5;

  // Status codes reported with every result item.
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADOP = 3'd4;

  // Result value select.
  localparam logic [2:0] SEL_ZERO = 3'd0;
  localparam logic [2:0] SEL_PUSH = 3'd1;
  localparam logic [2:0] SEL_TOP  = 3'd2;
  localparam logic [2:0] SEL_ADD  = 3'd3;
  localparam logic [2:0] SEL_SUB  = 3'd4;
  localparam logic [2:0] SEL_MUL  = 3'd5;
  localparam logic [2:0] SEL_DIV  = 3'd6;

  // Stack pointer update on commit.
  localparam logic [1:0] STK_PUSH  = 2'd0;
  localparam logic [1:0] STK_POP   = 2'd1;
  localparam logic [1:0] STK_CLEAR = 2'd2;

  // Divider iteration count.
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              load_mul;
    logic              start_div;
    logic              commit;
    logic [STAT_W-1:0] status;
    logic [2:0]        sel;
    logic [1:0]        stk;
    logic              fin;
  } pse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              sp_zero;
    logic              sp_lt2;
    logic              sp_full;
    logic              b_zero;
    logic              div_done;
  } pse_stat_t;

endpackage

// File: rtl/pse_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pse_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pse_pkg::DATA_W-1:0] dividend,
  input  logic [pse_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pse_pkg::DATA_W-1:0] quotient
);
  import pse_pkg::*;

  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    dvs_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [DATA_W-1:0]    mag_a, mag_b;
  logic [DATA_W:0]      rem_sh, diff;

  // Magnitudes of the operands; the most negative value maps to 2^31.
  assign mag_a = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;

  // One restoring step.
  always_comb begin
    rem_sh = {rem_r, quo_r[DATA_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    if (!diff[DATA_W]) begin
      rem_nxt = diff[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end
  end

  // Control: busy while the step count runs down from DIV_STEPS, done held until the next start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// File: rtl/pse_dpath.sv
// Datapath: operand stack memory, top-of-stack register, arithmetic and result register.
module pse_dpath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pse_pkg::MODE_W-1:0]  in_mode,
  input  logic signed [pse_pkg::DATA_W-1:0] in_operand_value,
  input  pse_pkg::pse_cmd_t           cmd,
  output pse_pkg::pse_stat_t          stat,
  output logic [pse_pkg::STAT_W-1:0]  out_status,
  output logic signed [pse_pkg::DATA_W-1:0] out_top_value,
  output logic [pse_pkg::COUNT_W-1:0] out_stack_count,
  output logic                        out_final_valid
);
  import pse_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  // The top entry lives in top_r; the memory holds the entries below it.
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

  logic [MODE_W-1:0]  mode_r;
  logic [DATA_W-1:0]  val_r;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic [DATA_W-1:0]  top_r;
  logic [DATA_W-1:0]  rd_r;
  logic [DATA_W-1:0]  prod_r;
  logic [STAT_W-1:0]  status_r;
  logic [DATA_W-1:0]  res_top_r;
  logic [COUNT_W-1:0] count_r;
  logic               fin_r;

  logic [SPW-1:0]     sp_m1, sp_m2;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic [DATA_W-1:0]  res;
  logic [DATA_W-1:0]  prod_full;
  logic               div_done;
  logic [DATA_W-1:0]  quo;

  assign sp_m1   = sp_r - SPW'(1);
  assign sp_m2   = sp_r - SPW'(2);
  assign rd_addr = sp_m2[AW-1:0];
  assign wr_addr = sp_m1[AW-1:0];
  assign wr_en   = cmd.commit && (cmd.stk == STK_PUSH) && (sp_r != '0);

  // Stack memory: one write port, one registered read of the second entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= top_r;
    end
    rd_r <= stack_mem[rd_addr];
  end

  // Token capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      val_r  <= in_operand_value;
    end
  end

  // Multiplier keeping only the low word, with its product registered before use.
  assign prod_full = rd_r * top_r;

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      prod_r <= prod_full;
    end
  end

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_div),
    .dividend (rd_r),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Result value select.
  always_comb begin
    unique case (cmd.sel)
      SEL_PUSH: res = val_r;
      SEL_TOP:  res = top_r;
      SEL_ADD:  res = rd_r + top_r;
      SEL_SUB:  res = rd_r - top_r;
      SEL_MUL:  res = prod_r;
      SEL_DIV:  res = quo;
      default:  res = '0;
    endcase
  end

  // Stack pointer update.
  always_comb begin
    unique case (cmd.stk)
      STK_PUSH: sp_nxt = sp_r + SPW'(1);
      STK_POP:  sp_nxt = sp_m1;
      default:  sp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.commit) begin
      sp_r <= sp_nxt;
    end
  end

  // Top-of-stack register and result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cmd.stk != STK_CLEAR) begin
        top_r <= res;
      end
      status_r  <= cmd.status;
      res_top_r <= res;
      count_r   <= COUNT_W'(sp_nxt);
      fin_r     <= cmd.fin;
    end
  end

  assign stat.mode     = mode_r;
  assign stat.sp_zero  = (sp_r == '0);
  assign stat.sp_lt2   = (sp_r < SPW'(2));
  assign stat.sp_full  = (sp_r == SPW'(STACK_DEPTH));
  assign stat.b_zero   = (top_r == '0);
  assign stat.div_done = div_done;

  assign out_status      = status_r;
  assign out_top_value   = res_top_r;
  assign out_stack_count = count_r;
  assign out_final_valid = fin_r;

endmodule

// File: rtl/pse_ctrl.sv
// Controller: token sequencing state machine and result valid flag.
module pse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pse_pkg::pse_stat_t  stat,
  output pse_pkg::pse_cmd_t   cmd
);
  import pse_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r;
  logic       slot_free;
  logic       done_now;

  // The result register can take a new item when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  // Decode of the current token and stack condition.
  always_comb begin
    cmd           = '0;
    cmd.status    = ST_OK;
    cmd.sel       = SEL_ZERO;
    cmd.stk       = STK_CLEAR;
    state_nxt     = state_r;
    done_now      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        done_now = 1'b1;
        if (stat.mode == MODE_PUSH) begin
          if (stat.sp_full) begin
            cmd.status = ST_OVER;
          end else begin
            cmd.sel = SEL_PUSH;
            cmd.stk = STK_PUSH;
          end
        end else if (stat.mode == MODE_END) begin
          if (stat.sp_zero) begin
            cmd.status = ST_UNDER;
          end else begin
            cmd.sel = SEL_TOP;
            cmd.fin = 1'b1;
          end
        end else if (stat.sp_lt2) begin
          cmd.status = ST_UNDER;
        end else if (stat.mode == MODE_ADD) begin
          cmd.sel = SEL_ADD;
          cmd.stk = STK_POP;
        end else if (stat.mode == MODE_SUB) begin
          cmd.sel = SEL_SUB;
          cmd.stk = STK_POP;
        end else if (stat.mode == MODE_MUL) begin
          done_now     = 1'b0;
          cmd.load_mul = 1'b1;
          state_nxt    = S_MUL;
        end else if (stat.mode == MODE_DIV) begin
          if (stat.b_zero) begin
            cmd.status = ST_DIVZ;
          end else begin
            done_now      = 1'b0;
            cmd.start_div = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.status = ST_BADOP;
        end
      end
      S_MUL: begin
        done_now = 1'b1;
        cmd.sel  = SEL_MUL;
        cmd.stk  = STK_POP;
      end
      S_DIV: begin
        done_now = stat.div_done;
        cmd.sel  = SEL_DIV;
        cmd.stk  = STK_POP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Finish the item once the result register has room.
    if (done_now && slot_free) begin
      cmd.commit = 1'b1;
      state_nxt  = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  // A result is never written over one that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed while output register full");

  // Every commit raises the output valid flag.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not produce a valid result");

  // A captured item is evaluated in the next cycle.
  a_capture_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_EVAL))
    else $error("captured item not evaluated");

  // A started division waits for the divider.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_div |=> ((state_r == S_DIV) && !stat.div_done))
    else $error("division start not followed by wait");

endmodule

// File: rtl/postfix_stack_evaluator.sv
// Postfix expression evaluator: top level joining controller and datapath.
//
// Usage: one parsed token enters per input item on in_valid/in_ready
// (in_mode, in_operand_value). Each token yields exactly one result item on
// out_valid/out_ready carrying out_status, out_top_value, out_stack_count and
// out_final_valid. Errors clear the stack and report a nonzero status.
// Timing: a token is taken in the idle state and evaluated the next cycle.
// Push, add, subtract, end and every error commit from the evaluate state;
// multiply first passes a state for the registered product, and divide waits
// in its own state for the 32-step bit-serial divider. The result is registered
// at commit. The stack top is held in a register and the entry below it is
// read from the stack memory through its single registered read port.
// Stall: the result sits in an output register; a new item is accepted while
// it waits, and evaluation holds before commit until the register drains.
// Reset (rst_n low, synchronous): stack empty, no result pending, idle.
// The stack memory needs no clearing, since only written entries are read.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pse_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [pse_pkg::DATA_W-1:0] in_operand_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pse_pkg::STAT_W-1:0]        out_status,
  output logic signed [pse_pkg::DATA_W-1:0] out_top_value,
  output logic [pse_pkg::COUNT_W-1:0]       out_stack_count,
  output logic                              out_final_valid
);
  import pse_pkg::*;

  pse_cmd_t  cmd;
  pse_stat_t stat;

  // Sequencing.
  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Stack, arithmetic and result register.
  pse_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_operand_value (in_operand_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_top_value    (out_top_value),
    .out_stack_count  (out_stack_count),
    .out_final_valid  (out_final_valid)
  );

endmodule
